// ----- rtl/core/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned TOP_ORDER_DEF = 14;
  localparam int unsigned PAGE_BITS     = 12;
  localparam logic [31:0] HEAP_BASE_RST = 32'h00A0_0000;

  localparam logic [7:0] TAG_ALLOC = 8'h80;
  localparam logic [7:0] TAG_USER  = 8'h40;
  localparam logic [7:0] TAG_MATCH = 8'hBF;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_FREE_ORD  = 2'd1,
    CMD_FREE_ADDR = 2'd2,
    CMD_FREE_USER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_NO_FREE  = 2'd1,
    STS_REJECT   = 2'd2,
    STS_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_SPLIT,
    ST_UL_RD,
    ST_UL_WR,
    ST_PUSH1,
    ST_PUSH2,
    ST_TAG_RD,
    ST_TAG_CHK,
    ST_MERGE_START,
    ST_MERGE_LOOP,
    ST_MERGE_CHK,
    ST_MERGE_NEXT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/bpa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_if
// Request and response channels of the buddy page allocator.
// ----------------------------------------------------------------------------
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  block_order;
  logic        user_owned;
  logic [31:0] address;

  modport source (output valid, command, block_order, user_owned, address, input ready);
  modport sink   (input valid, command, block_order, user_owned, address, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;

  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

// ----- rtl/core/bpa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/buddy_page_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Binary buddy allocator over 2^TOP_ORDER frames of 4 KiB.
//
// Usage: a request on in_req (valid/ready) carries a command, an order, a
// user flag and an address. Exactly one response leaves on out_rsp with
// the block address and a status. cfg_we/cfg_wdata write the heap base;
// write it only while no request is in flight.
// One request is handled at a time by a sequencer around the tag RAM and
// the two link RAMs, each with one read and one write port per cycle.
// Allocate searches the free lists upward from the asked order, unlinks the
// block found and splits it down level by level. Free merges buddies level
// by level; free by address reads the tag first. Free-all walks the tag
// table and frees each user-owned block, with its merges.
// in_req.ready is high only when idle and the response register is empty;
// a stalled receiver holds the response and blocks further requests.
// After reset a clearing pass rewrites every entry of the tag table;
// no request is taken meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top #(
  parameter int unsigned TOP_ORDER = bpa_pkg::TOP_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bpa_req_if.sink     in_req,
  bpa_rsp_if.source   out_rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned FW = TOP_ORDER;
  localparam int unsigned LW = FW + 1;
  localparam int unsigned NUM_FRAMES = 1 << TOP_ORDER;
  localparam int unsigned OW = $clog2(TOP_ORDER + 2);
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_FRAMES);
  localparam logic [5:0] TOP6 = 6'(TOP_ORDER);

  bpa_pkg::state_t state_r, state_nxt;
  bpa_pkg::cmd_t   cmd_r, cmd_nxt;
  bpa_pkg::status_t sts_r, sts_nxt;

  logic [31:0]   base_r;
  logic [5:0]    ord_r, ord_nxt;
  logic          user_r, user_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] f_r, f_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic [OW-1:0] lo_r, lo_nxt;
  logic [LW-1:0] hd_r, hd_nxt;
  logic [FW:0]   i_r, i_nxt;
  logic [31:0]   res_r, res_nxt;
  logic          ov_r, ov_nxt;
  logic [31:0]   oaddr_r, oaddr_nxt;
  logic [1:0]    osts_r, osts_nxt;
  logic [LW-1:0] heads_r [TOP_ORDER+1];
  logic [LW-1:0] heads_nxt [TOP_ORDER+1];

  logic          tag_we;
  logic [FW-1:0] tag_wa, tag_ra;
  logic [7:0]    tag_wd, tag_rd;
  logic          nx_we, pv_we;
  logic [FW-1:0] nx_wa, pv_wa, lk_ra;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

  logic [31:0]   off;
  logic          addr_ok;
  logic [FW-1:0] addr_idx;
  logic [FW-1:0] mbud, sbud;
  logic [LW-1:0] hsel;

  bpa_ram #(.WIDTH(8), .DEPTH(NUM_FRAMES)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd), .raddr(tag_ra), .rdata(tag_rd)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(lk_ra), .rdata(nx_rd)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(lk_ra), .rdata(pv_rd)
  );

  assign off      = addr_r - base_r;
  assign addr_ok  = (addr_r[bpa_pkg::PAGE_BITS-1:0] == '0) && (addr_r >= base_r) &&
                    ((off >> (bpa_pkg::PAGE_BITS + TOP_ORDER)) == 32'd0);
  assign addr_idx = off[bpa_pkg::PAGE_BITS +: FW];
  assign mbud     = idx_r ^ (FW'(1) << o_r);
  assign sbud     = idx_r ^ (FW'(1) << (o_r - 1'b1));
  assign hsel     = heads_r[lo_r];

  assign in_req.ready      = (state_r == bpa_pkg::ST_IDLE) && !ov_r;
  assign out_rsp.valid     = ov_r;
  assign out_rsp.block_address = oaddr_r;
  assign out_rsp.status    = osts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= bpa_pkg::HEAP_BASE_RST;
    end else if (cfg_we) begin
      base_r <= {cfg_wdata[31:bpa_pkg::PAGE_BITS], bpa_pkg::PAGE_BITS'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::ST_CLEAR;
      ov_r    <= 1'b0;
      i_r     <= '0;
      for (int k = 0; k <= TOP_ORDER; k++) begin
        heads_r[k] <= (k == TOP_ORDER) ? '0 : NULL_LINK;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      i_r     <= i_nxt;
      heads_r <= heads_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    sts_r   <= sts_nxt;
    ord_r   <= ord_nxt;
    user_r  <= user_nxt;
    addr_r  <= addr_nxt;
    idx_r   <= idx_nxt;
    f_r     <= f_nxt;
    o_r     <= o_nxt;
    lo_r    <= lo_nxt;
    hd_r    <= hd_nxt;
    res_r   <= res_nxt;
    oaddr_r <= oaddr_nxt;
    osts_r  <= osts_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    sts_nxt   = sts_r;
    ord_nxt   = ord_r;
    user_nxt  = user_r;
    addr_nxt  = addr_r;
    idx_nxt   = idx_r;
    f_nxt     = f_r;
    o_nxt     = o_r;
    lo_nxt    = lo_r;
    hd_nxt    = hd_r;
    i_nxt     = i_r;
    res_nxt   = res_r;
    oaddr_nxt = oaddr_r;
    osts_nxt  = osts_r;
    ov_nxt    = ov_r && !out_rsp.ready;
    heads_nxt = heads_r;
    tag_we = 1'b0; tag_wa = idx_r; tag_wd = '0; tag_ra = idx_r;
    nx_we  = 1'b0; nx_wa  = f_r;   nx_wd  = NULL_LINK;
    pv_we  = 1'b0; pv_wa  = f_r;   pv_wd  = NULL_LINK;
    lk_ra  = f_r;

    unique case (state_r)
      bpa_pkg::ST_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = i_r[FW-1:0];
        tag_wd = (i_r == '0) ? {2'b00, TOP6} : 8'd0;
        if (i_r == '0) begin
          nx_we = 1'b1; nx_wa = '0;
          pv_we = 1'b1; pv_wa = '0;
        end
        i_nxt = i_r + 1'b1;
        if (i_r == (FW+1)'(NUM_FRAMES - 1)) begin
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_IDLE: begin
        if (in_req.valid && in_req.ready) begin
          cmd_nxt   = bpa_pkg::cmd_t'(in_req.command);
          ord_nxt   = in_req.block_order;
          user_nxt  = in_req.user_owned;
          addr_nxt  = in_req.address;
          sts_nxt   = bpa_pkg::STS_DONE;
          res_nxt   = '0;
          state_nxt = bpa_pkg::ST_DECODE;
        end
      end
      bpa_pkg::ST_DECODE: begin
        unique case (cmd_r)
          bpa_pkg::CMD_ALLOC: begin
            if (ord_r > TOP6) begin
              sts_nxt = bpa_pkg::STS_REJECT; state_nxt = bpa_pkg::ST_DONE;
            end else begin
              o_nxt = OW'(ord_r); state_nxt = bpa_pkg::ST_SEARCH;
            end
          end
          bpa_pkg::CMD_FREE_ORD: begin
            if (addr_r == '0) begin
              state_nxt = bpa_pkg::ST_DONE;
            end else if (ord_r > TOP6 || !addr_ok) begin
              sts_nxt = bpa_pkg::STS_REJECT; state_nxt = bpa_pkg::ST_DONE;
            end else begin
              idx_nxt = addr_idx; o_nxt = OW'(ord_r); state_nxt = bpa_pkg::ST_MERGE_START;
            end
          end
          bpa_pkg::CMD_FREE_ADDR: begin
            if (addr_r == '0) begin
              state_nxt = bpa_pkg::ST_DONE;
            end else if (!addr_ok) begin
              sts_nxt = bpa_pkg::STS_REJECT; state_nxt = bpa_pkg::ST_DONE;
            end else begin
              idx_nxt = addr_idx; state_nxt = bpa_pkg::ST_TAG_RD;
            end
          end
          bpa_pkg::CMD_FREE_USER: begin
            i_nxt = '0; state_nxt = bpa_pkg::ST_WALK_RD;
          end
          default: state_nxt = bpa_pkg::ST_DONE;
        endcase
      end
      bpa_pkg::ST_SEARCH: begin
        if (6'(o_r) > TOP6) begin
          sts_nxt = bpa_pkg::STS_NO_FREE; state_nxt = bpa_pkg::ST_DONE;
        end else if (heads_r[o_r][FW]) begin
          o_nxt = o_r + 1'b1;
        end else begin
          idx_nxt = heads_r[o_r][FW-1:0];
          f_nxt   = heads_r[o_r][FW-1:0];
          lo_nxt  = o_r;
          state_nxt = bpa_pkg::ST_UL_RD;
        end
      end
      bpa_pkg::ST_UL_RD: begin
        lk_ra = f_r;
        state_nxt = bpa_pkg::ST_UL_WR;
      end
      bpa_pkg::ST_UL_WR: begin
        if (!pv_rd[FW]) begin
          nx_we = 1'b1; nx_wa = pv_rd[FW-1:0]; nx_wd = nx_rd;
        end else begin
          heads_nxt[lo_r] = nx_rd[FW] ? NULL_LINK : nx_rd;
        end
        if (!nx_rd[FW]) begin
          pv_we = 1'b1; pv_wa = nx_rd[FW-1:0]; pv_wd = pv_rd;
        end
        state_nxt = (cmd_r == bpa_pkg::CMD_ALLOC) ? bpa_pkg::ST_SPLIT : bpa_pkg::ST_MERGE_NEXT;
      end
      bpa_pkg::ST_SPLIT: begin
        if (6'(o_r) > ord_r) begin
          tag_we = 1'b1; tag_wa = sbud; tag_wd = {2'b00, 6'(o_r - 1'b1)};
          f_nxt  = sbud;
          lo_nxt = o_r - 1'b1;
          state_nxt = bpa_pkg::ST_PUSH1;
        end else begin
          tag_we = 1'b1; tag_wa = idx_r;
          tag_wd = {2'b00, ord_r} | bpa_pkg::TAG_ALLOC | (user_r ? bpa_pkg::TAG_USER : 8'd0);
          res_nxt = base_r + (32'(idx_r) << bpa_pkg::PAGE_BITS);
          state_nxt = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::ST_PUSH1: begin
        nx_we = 1'b1; nx_wa = f_r; nx_wd = hsel[FW] ? NULL_LINK : hsel;
        pv_we = 1'b1; pv_wa = f_r; pv_wd = NULL_LINK;
        heads_nxt[lo_r] = {1'b0, f_r};
        hd_nxt = hsel;
        state_nxt = bpa_pkg::ST_PUSH2;
      end
      bpa_pkg::ST_PUSH2: begin
        if (!hd_r[FW]) begin
          pv_we = 1'b1; pv_wa = hd_r[FW-1:0]; pv_wd = {1'b0, f_r};
        end
        priority case (cmd_r)
          bpa_pkg::CMD_ALLOC: begin
            o_nxt = o_r - 1'b1; state_nxt = bpa_pkg::ST_SPLIT;
          end
          bpa_pkg::CMD_FREE_USER: begin
            i_nxt = i_r + ((FW+1)'(1) << ord_r); state_nxt = bpa_pkg::ST_WALK_RD;
          end
          default: state_nxt = bpa_pkg::ST_DONE;
        endcase
      end
      bpa_pkg::ST_TAG_RD: begin
        tag_ra = idx_r;
        state_nxt = bpa_pkg::ST_TAG_CHK;
      end
      bpa_pkg::ST_TAG_CHK: begin
        if ((tag_rd & bpa_pkg::TAG_ALLOC) == 8'd0) begin
          sts_nxt = bpa_pkg::STS_NOT_ALLOC; state_nxt = bpa_pkg::ST_DONE;
        end else if (tag_rd[5:0] > TOP6) begin
          sts_nxt = bpa_pkg::STS_REJECT; state_nxt = bpa_pkg::ST_DONE;
        end else begin
          o_nxt = OW'(tag_rd[5:0]); state_nxt = bpa_pkg::ST_MERGE_START;
        end
      end
      bpa_pkg::ST_MERGE_START: begin
        tag_we = 1'b1; tag_wa = idx_r; tag_wd = {2'b00, 6'(o_r)};
        state_nxt = bpa_pkg::ST_MERGE_LOOP;
      end
      bpa_pkg::ST_MERGE_LOOP: begin
        if (6'(o_r) >= TOP6) begin
          f_nxt = idx_r; lo_nxt = o_r; state_nxt = bpa_pkg::ST_PUSH1;
        end else begin
          tag_ra = mbud; state_nxt = bpa_pkg::ST_MERGE_CHK;
        end
      end
      bpa_pkg::ST_MERGE_CHK: begin
        lo_nxt = o_r;
        if ((tag_rd & bpa_pkg::TAG_MATCH) != {2'b00, 6'(o_r)}) begin
          f_nxt = idx_r; state_nxt = bpa_pkg::ST_PUSH1;
        end else begin
          f_nxt = mbud; state_nxt = bpa_pkg::ST_UL_RD;
        end
      end
      bpa_pkg::ST_MERGE_NEXT: begin
        idx_nxt = idx_r & ~(FW'(1) << o_r);
        o_nxt   = o_r + 1'b1;
        tag_we  = 1'b1;
        tag_wa  = idx_r & ~(FW'(1) << o_r);
        tag_wd  = {2'b00, 6'(o_r + 1'b1)};
        state_nxt = bpa_pkg::ST_MERGE_LOOP;
      end
      bpa_pkg::ST_WALK_RD: begin
        tag_ra = i_r[FW-1:0];
        state_nxt = i_r[FW] ? bpa_pkg::ST_DONE : bpa_pkg::ST_WALK_CHK;
      end
      bpa_pkg::ST_WALK_CHK: begin
        if (tag_rd[7] && tag_rd[6] && tag_rd[5:0] <= TOP6) begin
          idx_nxt = i_r[FW-1:0];
          o_nxt   = OW'(tag_rd[5:0]);
          ord_nxt = tag_rd[5:0];
          state_nxt = bpa_pkg::ST_MERGE_START;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = bpa_pkg::ST_WALK_RD;
        end
      end
      bpa_pkg::ST_DONE: begin
        ov_nxt    = 1'b1;
        oaddr_nxt = res_r;
        osts_nxt  = sts_r;
        state_nxt = bpa_pkg::ST_IDLE;
      end
      default: state_nxt = bpa_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_addr_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.block_address != '0 |-> out_rsp.status == bpa_pkg::STS_DONE)
    else $error("address returned with failing status");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::ST_CLEAR |-> !in_req.ready)
    else $error("request taken during tag clear");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready && !out_rsp.valid)
    else $error("second request taken while busy");
`endif

endmodule
